/* rtl/core/lfu_cache_store_macros.svh */
// ----------------------------------------------------------------------------
// lfu_cache_store_macros.svh
// Assertion helpers used by the store's RTL.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_STORE_MACROS_SVH
`define LFU_CACHE_STORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define LFUCS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define LFUCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/lfucs_pkg.sv */
// ----------------------------------------------------------------------------
// lfucs_pkg
// Shared types and constants of the LFU key-value store.
// ----------------------------------------------------------------------------
package lfucs_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  // outcome of a lookup pass
  typedef struct packed {
    logic hit;     // key present
    logic victim;  // at least one valid entry seen
    logic free;    // empty slot inside capacity seen
  } scan_flags_t;

endpackage

/* rtl/core/lfucs_scan.sv */
// ----------------------------------------------------------------------------
// lfucs_scan
// Walks the entry stream of one read pass: finds the key, the eviction
// candidate (lowest count, oldest on ties) and the first empty slot.
// ----------------------------------------------------------------------------
module lfucs_scan #(
  parameter int IDX_W      = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      clear,
  input  logic                      vld,
  input  logic [IDX_W-1:0]          idx,
  input  logic                      ent_valid,
  input  logic                      in_slots,
  input  logic [lfucs_pkg::KEY_W-1:0] ent_key,
  input  logic [lfucs_pkg::VAL_W-1:0] ent_value,
  input  logic [COUNT_BITS-1:0]     ent_count,
  input  logic [IDX_W-1:0]          ent_rank,
  input  logic [lfucs_pkg::KEY_W-1:0] op_key,
  output lfucs_pkg::scan_flags_t    flags,
  output logic [IDX_W-1:0]          hit_idx,
  output logic [IDX_W-1:0]          hit_rank,
  output logic [lfucs_pkg::VAL_W-1:0] hit_value,
  output logic [IDX_W-1:0]          victim_idx,
  output logic [IDX_W-1:0]          victim_rank,
  output logic [IDX_W-1:0]          free_idx
);
  import lfucs_pkg::*;

  logic [COUNT_BITS-1:0] victim_count;
  logic                  better;

  assign better = !flags.victim || (ent_count < victim_count) ||
                  ((ent_count == victim_count) && (ent_rank > victim_rank));

  always_ff @(posedge clk) begin
    if (clear) begin
      flags <= '0;
    end else if (vld) begin
      if (ent_valid && (ent_key == op_key) && !flags.hit) begin
        flags.hit <= 1'b1;
        hit_idx   <= idx;
        hit_rank  <= ent_rank;
        hit_value <= ent_value;
      end
      if (ent_valid && better) begin
        flags.victim <= 1'b1;
        victim_idx   <= idx;
        victim_rank  <= ent_rank;
        victim_count <= ent_count;
      end
      if (!ent_valid && in_slots && !flags.free) begin
        flags.free <= 1'b1;
        free_idx   <= idx;
      end
    end
  end

endmodule

/* rtl/core/lfu_cache_store.sv */
// ----------------------------------------------------------------------------
// lfu_cache_store
// Key-value store with least-frequently-used replacement, oldest entry
// evicted among equal counts.
// ----------------------------------------------------------------------------
// One operation at a time. After start is taken, a read pass reads every
// entry of the entry RAM to match the key and pick the eviction candidate,
// then a write pass rewrites every entry to age the recency ranks. The
// result strobe (done) is high in S_DONE, which follows the write pass, and
// the next start is taken in the cycle after done. A get miss, or a put at
// capacity 0, skips the write pass and goes to S_DONE from S_DECIDE.
// Both passes use the single read port of the entry RAM; the write pass
// also uses its single write port.
// hit/read_value are registered in S_DECIDE and hold through the cycle done
// is high; the receiver must take them then. Writing capacity empties the
// store at once.
// ----------------------------------------------------------------------------
`include "lfu_cache_store_macros.svh"

module lfu_cache_store #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        func,
  input  logic [lfucs_pkg::KEY_W-1:0] key,
  input  logic [lfucs_pkg::VAL_W-1:0] value,
  output logic                        done,
  output logic                        hit,
  output logic [lfucs_pkg::VAL_W-1:0] read_value,
  input  logic                        cfg_we,
  input  logic [lfucs_pkg::CAP_W-1:0] cfg_wdata
);
  import lfucs_pkg::*;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SLOT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [VAL_W-1:0]      value;
    logic [COUNT_BITS-1:0] count;
    logic [IDX_W-1:0]      rank;
  } entry_t;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_DRAIN  = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_WRITE  = 7'b0010000,
    S_WDRAIN = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state;

  // entry RAM
  entry_t ram [ENTRIES];
  entry_t rd_data;
  entry_t wr_data;
  logic   wr_en;

  logic [IDX_W-1:0]  cnt;
  logic              pipe_vld;
  logic [IDX_W-1:0]  pipe_idx;
  logic [ENTRIES-1:0] valid;
  logic [SLOT_W-1:0] total;
  logic [CAP_W-1:0]  capacity;
  logic [SLOT_W-1:0] slots;

  // latched operation
  logic             op_func;
  logic [KEY_W-1:0] op_key;
  logic [VAL_W-1:0] op_value;

  // write pass plan
  logic             wb_insert;
  logic             wb_evict;
  logic [IDX_W-1:0] wb_target;
  logic [IDX_W-1:0] wb_rank;

  scan_flags_t      flags;
  logic [IDX_W-1:0] hit_idx, hit_rank, victim_idx, victim_rank, free_idx;
  logic [VAL_W-1:0] hit_value;

  logic accept;
  logic do_write;
  logic evict_now;
  logic new_key;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);
  assign done   = (state == S_DONE);
  assign slots  = (int'(capacity) > ENTRIES) ? SLOT_W'(ENTRIES) : SLOT_W'(capacity);

  assign do_write  = (op_func == FUNC_GET) ? flags.hit : (slots != '0);
  assign evict_now = (total >= slots);
  assign new_key   = (state == S_DECIDE) && do_write && !flags.hit;

  always_ff @(posedge clk) begin
    rd_data <= ram[cnt];
    if (wr_en) begin
      ram[pipe_idx] <= wr_data;
    end
  end

  lfucs_scan #(
    .IDX_W      (IDX_W),
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk         (clk),
    .clear       (state == S_IDLE),
    .vld         (pipe_vld && ((state == S_SCAN) || (state == S_DRAIN))),
    .idx         (pipe_idx),
    .ent_valid   (valid[pipe_idx]),
    .in_slots    (SLOT_W'(pipe_idx) < slots),
    .ent_key     (rd_data.key),
    .ent_value   (rd_data.value),
    .ent_count   (rd_data.count),
    .ent_rank    (rd_data.rank),
    .op_key      (op_key),
    .flags       (flags),
    .hit_idx     (hit_idx),
    .hit_rank    (hit_rank),
    .hit_value   (hit_value),
    .victim_idx  (victim_idx),
    .victim_rank (victim_rank),
    .free_idx    (free_idx)
  );

  // write-back of the entry read in the previous cycle
  always_comb begin
    wr_data = rd_data;
    wr_en   = 1'b0;
    if (pipe_vld && ((state == S_WRITE) || (state == S_WDRAIN))) begin
      if (pipe_idx == wb_target) begin
        wr_en        = 1'b1;
        wr_data.rank = '0;
        if (wb_insert) begin
          wr_data.key   = op_key;
          wr_data.value = op_value;
          wr_data.count = COUNT_BITS'(1);
        end else begin
          if (op_func == FUNC_PUT) begin
            wr_data.value = op_value;
          end
          if (rd_data.count != '1) begin
            wr_data.count = rd_data.count + COUNT_BITS'(1);
          end
        end
      end else if (valid[pipe_idx]) begin
        wr_en = 1'b1;
        if (wb_insert) begin
          // evicted rank closes its gap, then all age by one
          if (!(wb_evict && (rd_data.rank > wb_rank))) begin
            wr_data.rank = rd_data.rank + IDX_W'(1);
          end
        end else if (rd_data.rank < wb_rank) begin
          wr_data.rank = rd_data.rank + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      pipe_vld <= 1'b0;
      valid    <= '0;
      total    <= '0;
      capacity <= CAP_RESET;
    end else begin
      pipe_vld <= (state == S_SCAN) || (state == S_WRITE);
      pipe_idx <= cnt;
      if (cfg_we) begin
        capacity <= cfg_wdata;
        valid    <= '0;
        total    <= '0;
      end
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (accept) begin
            op_func  <= func;
            op_key   <= key;
            op_value <= value;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt == LAST) begin
            cnt   <= '0;
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          hit        <= flags.hit;
          read_value <= (op_func == FUNC_GET && flags.hit) ? hit_value : '0;
          if (new_key) begin
            wb_insert <= 1'b1;
            wb_evict  <= evict_now;
            wb_rank   <= victim_rank;
            if (evict_now) begin
              wb_target <= victim_idx;
              valid[victim_idx] <= 1'b1;
            end else begin
              wb_target <= free_idx;
              valid[free_idx] <= 1'b1;
              total <= total + SLOT_W'(1);
            end
          end else begin
            wb_insert <= 1'b0;
            wb_evict  <= 1'b0;
            wb_target <= hit_idx;
            wb_rank   <= hit_rank;
          end
          state <= do_write ? S_WRITE : S_DONE;
        end
        S_WRITE: begin
          if (cnt == LAST) begin
            cnt   <= '0;
            state <= S_WDRAIN;
          end else begin
            cnt <= cnt + IDX_W'(1);
          end
        end
        S_WDRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `LFUCS_ASSERT_IMPL(a_total_in_cap, 1'b1, total <= slots, "entry total above capacity")
  `LFUCS_ASSERT_NEXT(a_done_frees, done, !busy, "busy after result beat")
  `LFUCS_ASSERT_IMPL(a_insert_slot, new_key && !evict_now, flags.free, "insert with no free slot")
  `LFUCS_ASSERT_IMPL(a_evict_cand, new_key && evict_now, flags.victim, "eviction with no candidate")

endmodule
